// File: hw/rtl/assert_macros.svh
// Assertion macros used by the dispatcher datapath.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ((a) |-> (b))) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ((a) |=> (b))) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, a, b)
`define ASSERT_NEXT(lbl, a, b)
`endif
`endif

// File: hw/rtl/pjd_pkg.sv
// Types and constants for the priority job dispatcher.
// No dependencies.
package pjd_pkg;
    localparam int MAX_DISPATCH = 4;

    localparam logic [1:0] REQ_SUBMIT = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam logic [1:0] PRI_LOW    = 2'd0;
    localparam logic [1:0] PRI_NORMAL = 2'd1;
    localparam logic [1:0] PRI_HIGH   = 2'd2;

    localparam logic [2:0] EV_DISPATCHED = 3'd0;
    localparam logic [2:0] EV_QUEUED     = 3'd1;
    localparam logic [2:0] EV_DROPPED    = 3'd2;
    localparam logic [2:0] EV_COMPLETED  = 3'd3;
    localparam logic [2:0] EV_TICK_END   = 3'd4;
    localparam logic [2:0] EV_IGNORED    = 3'd5;

    localparam logic [2:0] CFG_ACTIVE = 3'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SUBMIT,
        ST_FINISH,
        ST_TICK_READ,
        ST_TICK_WAIT,
        ST_TICK_EVAL,
        ST_TICK_END,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       load_req;
        logic       do_submit;
        logic       do_finish;
        logic       do_head;
        logic       next_queue;
        logic       do_tick_end;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       head_ok;
        logic       queue_empty;
        logic       last_queue;
        logic       limit_hit;
        logic       out_busy;
    } ctl_sts_t;
endpackage

// File: hw/rtl/pjd_if.sv
// Valid/ready channel interface carrying one payload struct.
// Depends on nothing beyond its type parameter.
interface pjd_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/priority_job_dispatcher.sv
// Priority job dispatcher top level. A submit or finish result is
// registered after its request passes the decode state and then the submit
// or finish state; a new request is taken only in idle once the last result
// is accepted. A tick skips each empty queue, examines queue heads (at most seven), then ends.
// Reset: all workers idle, queues empty, four workers active with all-ones
// masks. Depends on pjd_pkg, pjd_if, pjd_ctrl and pjd_datapath.
module priority_job_dispatcher
    import pjd_pkg::*;
#(
    parameter int NUM_WORKERS = 4,
    parameter int QUEUE_DEPTH = 256,
    parameter int TAG_WIDTH   = 16,
    parameter int TYPE_WIDTH  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    pjd_if.sink        req,
    pjd_if.source      rsp
);
    ctl_cmd_t cmd;
    ctl_sts_t sts;

    pjd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pjd_datapath #(
        .NUM_WORKERS (NUM_WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH),
        .TYPE_WIDTH  (TYPE_WIDTH),
        .WIDX_WIDTH  (2),
        .CFG_WIDTH   (8)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_type        (req.data.req_type),
        .job_type        (req.data.job_type),
        .prio_level      (req.data.prio_level),
        .job_tag         (req.data.job_tag),
        .worker_index    (req.data.worker_index),
        .job_succeeded   (req.data.job_succeeded),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .event_kind      (rsp.data.event_kind),
        .assigned_worker (rsp.data.assigned_worker),
        .result_tag      (rsp.data.result_tag),
        .job_outcome     (rsp.data.job_outcome),
        .last            (rsp.data.last)
    );
endmodule

// File: hw/rtl/pjd_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module pjd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/pjd_ctrl.sv
// Sequencer of the dispatcher: steps requests through decode, submit,
// finish and the tick drain loop. Depends on pjd_pkg.
module pjd_ctrl
    import pjd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !sts.out_busy;
                if (in_valid && !sts.out_busy)
                begin
                    cmd.load_req = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.req)
                    REQ_SUBMIT: state_next = ST_SUBMIT;
                    REQ_TICK:   state_next = ST_TICK_READ;
                    default:    state_next = ST_FINISH;
                endcase
            end
            ST_SUBMIT:
            begin
                cmd.do_submit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FINISH:
            begin
                cmd.do_finish = 1'b1;
                state_next = ST_IDLE;
            end
            ST_TICK_READ:
            begin
                if (sts.limit_hit)
                begin
                    state_next = ST_TICK_END;
                end
                else if (sts.queue_empty)
                begin
                    if (sts.last_queue)
                    begin
                        state_next = ST_TICK_END;
                    end
                    else
                    begin
                        cmd.next_queue = 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_TICK_WAIT;
                end
            end
            ST_TICK_WAIT:
            begin
                state_next = ST_TICK_EVAL;
            end
            ST_TICK_EVAL:
            begin
                if (sts.out_busy)
                begin
                    state_next = ST_TICK_EVAL;
                end
                else if (sts.head_ok)
                begin
                    cmd.do_head = 1'b1;
                    state_next = ST_TICK_READ;
                end
                else if (sts.last_queue)
                begin
                    state_next = ST_TICK_END;
                end
                else
                begin
                    cmd.next_queue = 1'b1;
                    state_next = ST_TICK_READ;
                end
            end
            ST_TICK_END:
            begin
                if (!sts.out_busy)
                begin
                    cmd.do_tick_end = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// File: hw/rtl/pjd_datapath.sv
// Datapath of the dispatcher: worker table, three job queues in RAM,
// worker match and result register. Depends on pjd_pkg, pjd_ram and assert_macros.svh.
`include "assert_macros.svh"
module pjd_datapath
    import pjd_pkg::*;
#(
    parameter int NUM_WORKERS = 4,
    parameter int QUEUE_DEPTH = 256,
    parameter int TAG_WIDTH   = 16,
    parameter int TYPE_WIDTH  = 8,
    parameter int WIDX_WIDTH  = 2,
    parameter int CFG_WIDTH   = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic [1:0]             req_type,
    input  logic [TYPE_WIDTH-1:0]  job_type,
    input  logic [1:0]             prio_level,
    input  logic [TAG_WIDTH-1:0]   job_tag,
    input  logic [WIDX_WIDTH-1:0]  worker_index,
    input  logic                   job_succeeded,
    input  ctl_cmd_t               cmd,
    output ctl_sts_t               sts,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             event_kind,
    output logic [WIDX_WIDTH-1:0]  assigned_worker,
    output logic [TAG_WIDTH-1:0]   result_tag,
    output logic                   job_outcome,
    output logic                   last
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = TYPE_WIDTH + TAG_WIDTH;
    localparam int WW = $clog2(NUM_WORKERS + 1);

    logic [2:0]            active_reg;
    logic [TYPE_WIDTH-1:0] mask_reg [NUM_WORKERS];
    logic [NUM_WORKERS-1:0] busy_reg, busy_next;
    logic [TAG_WIDTH-1:0]  wtag_reg [NUM_WORKERS];

    logic [1:0]            req_reg;
    logic [TYPE_WIDTH-1:0] type_reg;
    logic [1:0]            pri_reg;
    logic [TAG_WIDTH-1:0]  tag_reg;
    logic [WIDX_WIDTH-1:0] widx_reg;
    logic                  ok_reg;

    logic [PW-1:0] rptr_reg [3];
    logic [PW-1:0] wptr_reg [3];
    logic [CW-1:0] cnt_reg [3];
    logic [1:0]    q_reg;
    logic [2:0]    disp_reg;

    logic          ov_reg;
    logic [2:0]    ek_reg;
    logic [WIDX_WIDTH-1:0] aw_reg;
    logic [TAG_WIDTH-1:0]  rt_reg;
    logic          jo_reg;
    logic          last_reg;

    logic [EW-1:0] rdata [3];
    logic [EW-1:0] head;
    logic [WW-1:0] limit;
    logic [TYPE_WIDTH-1:0] match_type;
    logic          found;
    logic [WIDX_WIDTH-1:0] found_idx;
    logic [1:0]    sub_q;
    logic          sub_dispatch;
    logic          sub_full;
    logic          fin_ok;

    assign limit = (32'(active_reg) > NUM_WORKERS) ? WW'(NUM_WORKERS) : WW'(active_reg);
    assign head = rdata[q_reg];
    assign match_type = (req_reg == REQ_TICK) ? head[EW-1:TAG_WIDTH] : type_reg;

    always_comb
    begin
        found = 1'b0;
        found_idx = '0;
        for (int i = NUM_WORKERS - 1; i >= 0; i--)
        begin
            if (WW'(i) < limit && !busy_reg[i] && ((mask_reg[i] & match_type) != '0))
            begin
                found = 1'b1;
                found_idx = WIDX_WIDTH'(i);
            end
        end
    end

    always_comb
    begin
        sub_dispatch = (pri_reg == PRI_HIGH) && found;
        case (pri_reg)
            PRI_HIGH: sub_q = 2'd2;
            PRI_LOW:  sub_q = 2'd0;
            default:  sub_q = 2'd1;
        endcase
        sub_full = cnt_reg[sub_q] == CW'(QUEUE_DEPTH);
        fin_ok = (req_reg == REQ_FINISH) && (32'(widx_reg) < NUM_WORKERS)
            && busy_reg[widx_reg];
    end

    assign sts.req = req_reg;
    assign sts.head_ok = found;
    assign sts.queue_empty = cnt_reg[q_reg] == '0;
    assign sts.last_queue = q_reg == 2'd0;
    assign sts.limit_hit = disp_reg == 3'(MAX_DISPATCH);
    assign sts.out_busy = ov_reg;

    for (genvar g = 0; g < 3; g++)
    begin : g_q
        pjd_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
            .clk   (clk),
            .we    (cmd.do_submit && !sub_dispatch && !sub_full && sub_q == 2'(g)),
            .waddr (wptr_reg[g]),
            .wdata ({type_reg, tag_reg}),
            .raddr (rptr_reg[g]),
            .rdata (rdata[g])
        );
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.do_submit && sub_dispatch)
        begin
            busy_next[found_idx] = 1'b1;
        end
        if (cmd.do_head)
        begin
            busy_next[found_idx] = 1'b1;
        end
        if (cmd.do_finish && fin_ok)
        begin
            busy_next[widx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg  <= req_type;
            type_reg <= job_type;
            pri_reg  <= prio_level;
            tag_reg  <= job_tag;
            widx_reg <= worker_index;
            ok_reg   <= job_succeeded;
        end
        if (cmd.do_submit && sub_dispatch)
        begin
            wtag_reg[found_idx] <= tag_reg;
        end
        if (cmd.do_head)
        begin
            wtag_reg[found_idx] <= head[TAG_WIDTH-1:0];
        end
        if (cmd.do_submit || cmd.do_finish || cmd.do_head || cmd.do_tick_end)
        begin
            ek_reg   <= EV_IGNORED;
            aw_reg   <= '0;
            rt_reg   <= '0;
            jo_reg   <= 1'b0;
            last_reg <= 1'b1;
            if (cmd.do_submit)
            begin
                rt_reg <= tag_reg;
                if (sub_dispatch)
                begin
                    ek_reg <= EV_DISPATCHED;
                    aw_reg <= found_idx;
                end
                else
                begin
                    ek_reg <= sub_full ? EV_DROPPED : EV_QUEUED;
                end
            end
            if (cmd.do_finish && req_reg == REQ_FINISH && fin_ok)
            begin
                ek_reg <= EV_COMPLETED;
                aw_reg <= widx_reg;
                rt_reg <= wtag_reg[widx_reg];
                jo_reg <= ok_reg;
            end
            if (cmd.do_head)
            begin
                ek_reg   <= EV_DISPATCHED;
                aw_reg   <= found_idx;
                rt_reg   <= head[TAG_WIDTH-1:0];
                last_reg <= 1'b0;
            end
            if (cmd.do_tick_end)
            begin
                ek_reg <= EV_TICK_END;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 3'd4;
            for (int i = 0; i < NUM_WORKERS; i++)
            begin
                mask_reg[i] <= '1;
            end
            busy_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                rptr_reg[i] <= '0;
                wptr_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            q_reg    <= 2'd2;
            disp_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ACTIVE)
                begin
                    active_reg <= cfg_data[2:0];
                end
                for (int i = 0; i < NUM_WORKERS; i++)
                begin
                    if (32'(cfg_index) == i + 1)
                    begin
                        mask_reg[i] <= cfg_data[TYPE_WIDTH-1:0];
                    end
                end
            end
            busy_reg <= busy_next;
            if (cmd.load_req)
            begin
                q_reg    <= 2'd2;
                disp_reg <= '0;
            end
            if (cmd.next_queue)
            begin
                q_reg <= q_reg - 2'd1;
            end
            if (cmd.do_submit && !sub_dispatch && !sub_full)
            begin
                wptr_reg[sub_q] <= (32'(wptr_reg[sub_q]) == QUEUE_DEPTH - 1)
                    ? '0 : wptr_reg[sub_q] + PW'(1);
                cnt_reg[sub_q] <= cnt_reg[sub_q] + CW'(1);
            end
            if (cmd.do_head)
            begin
                rptr_reg[q_reg] <= (32'(rptr_reg[q_reg]) == QUEUE_DEPTH - 1)
                    ? '0 : rptr_reg[q_reg] + PW'(1);
                cnt_reg[q_reg] <= cnt_reg[q_reg] - CW'(1);
                disp_reg <= disp_reg + 3'd1;
            end
            if (cmd.do_submit || cmd.do_finish || cmd.do_head || cmd.do_tick_end)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = ov_reg;
    assign event_kind      = ek_reg;
    assign assigned_worker = aw_reg;
    assign result_tag      = rt_reg;
    assign job_outcome     = jo_reg;
    assign last            = last_reg;

    `ASSERT_IMPL(a_no_overwrite, ov_reg && !out_ready, !(cmd.do_head || cmd.do_tick_end))
    `ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg[q_reg] <= CW'(QUEUE_DEPTH))
    `ASSERT_IMPL(a_disp_bound, 1'b1, disp_reg <= 3'(MAX_DISPATCH))
    `ASSERT_NEXT(a_head_sets_busy, cmd.do_head, busy_reg != '0)
endmodule
